>>> rtl/rdsps_pkg.sv
// Package for the RDS program service name segment voter.
// Holds the beat types, register indexes, quality constants and small helper functions.
// No dependencies; used by rds_ps_name_segment_vote.
package rdsps_pkg;

    // Fixed segment layout of the eight-character name.
    localparam int SEG_COUNT  = 4;
    localparam int SEG_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int SEG_DATA_W = 2 * CHAR_W;
    localparam int TIME_W     = 32;
    localparam int THR_W      = 4;
    localparam int QUAL_W     = 7;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COMMIT_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUAL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRESH_MS   = 2'd3;

    // Register reset values.
    localparam logic [THR_W-1:0]      RST_COMMIT_THR = 4'd3;
    localparam logic [THR_W-1:0]      RST_CHANGE_THR = 4'd4;
    localparam logic [QUAL_W-1:0]     RST_MIN_QUAL   = 7'd30;
    localparam logic [CFG_DATA_W-1:0] RST_FRESH_MS   = 32'd4000;

    // Group quality terms.
    localparam int QUAL_BASE    = 30;
    localparam int SNR_CAP      = 60;
    localparam int SNR_CAP_DB   = 20;
    localparam int SNR_GAIN     = 3;
    localparam int ERR_MAX_GAIN = 18;
    localparam int ERR_SUM_GAIN = 4;
    localparam int QUAL_MAX     = 100;

    // Block acceptance and group type.
    localparam logic [1:0] ERR_GOOD_MAX = 2'd1;
    localparam logic [3:0] GTYPE_PS     = 4'd0;

    // Printable character range and its substitute.
    localparam logic [CHAR_W-1:0] CHAR_LO    = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_HI    = 8'h7E;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // Margin a vote winner needs over the runner-up.
    localparam int VOTE_MARGIN = 2;

    // One decoded RDS group.
    typedef struct packed {
        logic [3:0]            group_type;
        logic [1:0]            err_a;
        logic [1:0]            err_b;
        logic [1:0]            err_c;
        logic [1:0]            err_d;
        logic [15:0]           word_b;
        logic [15:0]           word_d;
        logic [6:0]            snr_db;
        logic [TIME_W-1:0]     time_ms;
    } t_in_beat;

    // Result of one group.
    typedef struct packed {
        logic                  group_used;
        logic                  name_ready;
        logic [63:0]           name_text;
    } t_out_beat;

    // Replace a non-printable byte by a space.
    function automatic logic [CHAR_W-1:0] clean_char(input logic [CHAR_W-1:0] b);
        return (b >= CHAR_LO && b <= CHAR_HI) ? b : CHAR_SPACE;
    endfunction

    function automatic logic [TIME_W-1:0] max2(input logic [TIME_W-1:0] a,
                                              input logic [TIME_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [TIME_W-1:0] min2(input logic [TIME_W-1:0] a,
                                              input logic [TIME_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

>>> rtl/rds_ps_name_segment_vote.sv
// RDS program service name segment voter, top level.
// Depends on rdsps_pkg for beat types, register indexes and constants.
// Accepted groups are registered, voted and reported from a result register.

// The block accepts one decoded RDS group per clock cycle while not stalled and returns
// exactly one result beat per group via the input, then the result register. Quality
// gating, the five-sample majority vote of the addressed segment, the commit decision
// and the freshness check are all combinational between the two registers; the segment
// state is updated with the result register, so a group for the same segment can follow
// directly. The input side stalls only while a result waits and the output side stalls.
// Configuration writes are always taken and should be made while no group is in flight.
// The vote window is undefined after reset; only entries already written are voted.
module rds_ps_name_segment_vote #(
    parameter int VOTE_DEPTH = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Group input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rdsps_pkg::t_in_beat                 i_in_data,
    // Result output channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rdsps_pkg::t_out_beat                o_out_data,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rdsps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rdsps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CNT_W  = $clog2(VOTE_DEPTH + 1);
    localparam int SLOT_W = $clog2(VOTE_DEPTH);
    localparam int CMP_W  = ((CNT_W > rdsps_pkg::THR_W) ? CNT_W : rdsps_pkg::THR_W) + 1;
    localparam int SEGS   = rdsps_pkg::SEG_COUNT;
    localparam int SDW    = rdsps_pkg::SEG_DATA_W;
    localparam int TW     = rdsps_pkg::TIME_W;

    // Configuration registers.
    logic [rdsps_pkg::THR_W-1:0]      r_commit_thr;
    logic [rdsps_pkg::THR_W-1:0]      r_change_thr;
    logic [rdsps_pkg::QUAL_W-1:0]     r_min_qual;
    logic [rdsps_pkg::CFG_DATA_W-1:0] r_fresh_ms;

    // Pipeline registers.
    logic                   r_in_valid;
    rdsps_pkg::t_in_beat    r_in;
    logic                   r_out_valid;
    rdsps_pkg::t_out_beat   r_out;
    rdsps_pkg::t_out_beat   n_out;

    // Segment state.
    logic [SDW-1:0]    r_win [SEGS][VOTE_DEPTH];
    logic [CNT_W-1:0]  r_fill [SEGS];
    logic [SLOT_W-1:0] r_slot [SEGS];
    logic [SEGS-1:0]   r_committed;
    logic [SDW-1:0]    r_value [SEGS];
    logic [TW-1:0]     r_ctime [SEGS];

    logic [CNT_W-1:0]  n_fill;
    logic [SLOT_W-1:0] n_slot;
    logic [SEGS-1:0]   n_committed;

    // Handshake and datapath signals.
    logic                            advance;
    logic                            accept_in;
    logic [6:0]                      snr_term;
    logic [1:0]                      err_max;
    logic [3:0]                      err_sum;
    logic [9:0]                      qual_raw;
    logic [rdsps_pkg::QUAL_W-1:0]    qual;
    logic                            use_group;
    logic [SDW-1:0]                  sample;
    logic [rdsps_pkg::SEG_W-1:0]     seg;
    logic [SDW-1:0]                  row [VOTE_DEPTH];
    logic [VOTE_DEPTH-1:0]           live;
    logic [CNT_W-1:0]                cnt [VOTE_DEPTH];
    logic [CNT_W-1:0]                win_cnt;
    logic [CNT_W-1:0]                run_cnt;
    logic [SDW-1:0]                  winner;
    logic [CMP_W-1:0]                win_cmp;
    logic [CMP_W-1:0]                run_cmp;
    logic                            commit_ok;
    logic                            do_commit;
    logic [TW-1:0]                   t_new [SEGS];
    logic [TW-1:0]                   mx_keep;
    logic [TW-1:0]                   mn_keep;
    logic [TW-1:0]                   mx_new;
    logic [TW-1:0]                   mn_new;
    logic                            ready_keep;
    logic                            ready_new;

    // Flow control: the result register is free when empty or being drained.
    assign advance     = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign accept_in   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Group quality and gating.
    always_comb begin
        snr_term = (r_in.snr_db >= 7'(rdsps_pkg::SNR_CAP_DB)) ? 7'(rdsps_pkg::SNR_CAP)
                                                              : 7'(r_in.snr_db * 7'(rdsps_pkg::SNR_GAIN));
        err_max = r_in.err_a;
        if (r_in.err_b > err_max) err_max = r_in.err_b;
        if (r_in.err_c > err_max) err_max = r_in.err_c;
        if (r_in.err_d > err_max) err_max = r_in.err_d;
        err_sum = 4'(r_in.err_a) + 4'(r_in.err_b) + 4'(r_in.err_c) + 4'(r_in.err_d);
        qual_raw = 10'(rdsps_pkg::QUAL_BASE) + 10'(snr_term)
                 - 10'(rdsps_pkg::ERR_MAX_GAIN * err_max)
                 - 10'(rdsps_pkg::ERR_SUM_GAIN * err_sum);
        if (qual_raw[9]) begin
            qual = '0;
        end else if (qual_raw > 10'(rdsps_pkg::QUAL_MAX)) begin
            qual = 7'(rdsps_pkg::QUAL_MAX);
        end else begin
            qual = qual_raw[6:0];
        end
        use_group = (r_in.group_type == rdsps_pkg::GTYPE_PS)
                 && (r_in.err_b <= rdsps_pkg::ERR_GOOD_MAX)
                 && (r_in.err_d <= rdsps_pkg::ERR_GOOD_MAX)
                 && (qual >= r_min_qual);
        sample = {rdsps_pkg::clean_char(r_in.word_d[15:8]),
                  rdsps_pkg::clean_char(r_in.word_d[7:0])};
        seg = r_in.word_b[rdsps_pkg::SEG_W-1:0];
    end

    // Window of the addressed segment with the new sample already in place.
    always_comb begin
        n_fill = (r_fill[seg] < CNT_W'(VOTE_DEPTH)) ? r_fill[seg] + CNT_W'(1) : r_fill[seg];
        n_slot = (r_slot[seg] == SLOT_W'(VOTE_DEPTH - 1)) ? '0 : r_slot[seg] + SLOT_W'(1);
        for (int k = 0; k < VOTE_DEPTH; k++) begin
            row[k]  = (r_slot[seg] == SLOT_W'(k)) ? sample : r_win[seg][k];
            live[k] = CNT_W'(k) < n_fill;
        end
    end

    // Match count of every window entry.
    always_comb begin
        for (int i = 0; i < VOTE_DEPTH; i++) begin
            cnt[i] = '0;
            for (int j = 0; j < VOTE_DEPTH; j++) begin
                if (live[j] && row[j] == row[i]) cnt[i] = cnt[i] + CNT_W'(1);
            end
        end
    end

    // Winner scan in storage order; ties go to the current segment value.
    always_comb begin
        win_cnt = '0;
        run_cnt = '0;
        winner  = '0;
        for (int i = 0; i < VOTE_DEPTH; i++) begin
            if (live[i]) begin
                if (cnt[i] > win_cnt || (cnt[i] == win_cnt && row[i] == r_value[seg])) begin
                    run_cnt = win_cnt;
                    win_cnt = cnt[i];
                    winner  = row[i];
                end else if (cnt[i] > run_cnt && row[i] != winner) begin
                    run_cnt = cnt[i];
                end
            end
        end
    end

    // Commit decision with hysteresis.
    always_comb begin
        win_cmp = CMP_W'(win_cnt);
        run_cmp = CMP_W'(run_cnt) + CMP_W'(rdsps_pkg::VOTE_MARGIN);
        if (r_committed[seg]) begin
            if (winner == r_value[seg]) begin
                commit_ok = win_cmp >= CMP_W'(r_commit_thr);
            end else begin
                commit_ok = (win_cmp >= CMP_W'(r_change_thr)) && (win_cmp >= run_cmp);
            end
        end else begin
            commit_ok = (win_cmp >= CMP_W'(r_commit_thr)) && (win_cmp >= run_cmp);
        end
        do_commit = use_group && commit_ok;
    end

    // Freshness for both outcomes, worked out alongside the vote.
    always_comb begin
        for (int s = 0; s < SEGS; s++) begin
            t_new[s] = (seg == rdsps_pkg::SEG_W'(s)) ? r_in.time_ms : r_ctime[s];
        end
        mx_keep = rdsps_pkg::max2(rdsps_pkg::max2(r_ctime[0], r_ctime[1]),
                                  rdsps_pkg::max2(r_ctime[2], r_ctime[3]));
        mn_keep = rdsps_pkg::min2(rdsps_pkg::min2(r_ctime[0], r_ctime[1]),
                                  rdsps_pkg::min2(r_ctime[2], r_ctime[3]));
        mx_new  = rdsps_pkg::max2(rdsps_pkg::max2(t_new[0], t_new[1]),
                                  rdsps_pkg::max2(t_new[2], t_new[3]));
        mn_new  = rdsps_pkg::min2(rdsps_pkg::min2(t_new[0], t_new[1]),
                                  rdsps_pkg::min2(t_new[2], t_new[3]));
        n_committed = r_committed;
        n_committed[seg] = 1'b1;
        ready_keep = (&r_committed) && ((mx_keep - mn_keep) <= r_fresh_ms)
                  && ((r_in.time_ms - mx_keep) <= r_fresh_ms);
        ready_new  = (&n_committed) && ((mx_new - mn_new) <= r_fresh_ms)
                  && ((r_in.time_ms - mx_new) <= r_fresh_ms);
    end

    // Result beat built from the state as it stands after this group.
    always_comb begin
        n_out.group_used = use_group;
        n_out.name_ready = do_commit ? ready_new : ready_keep;
        for (int s = 0; s < SEGS; s++) begin
            if (do_commit && seg == rdsps_pkg::SEG_W'(s)) begin
                n_out.name_text[(SEGS-1-s)*SDW +: SDW] = winner;
            end else if (r_committed[s]) begin
                n_out.name_text[(SEGS-1-s)*SDW +: SDW] = r_value[s];
            end else begin
                n_out.name_text[(SEGS-1-s)*SDW +: SDW] = '0;
            end
        end
    end

    // Handshake control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept_in) r_in <= i_in_data;
        if (advance) r_out <= n_out;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_commit_thr <= rdsps_pkg::RST_COMMIT_THR;
            r_change_thr <= rdsps_pkg::RST_CHANGE_THR;
            r_min_qual   <= rdsps_pkg::RST_MIN_QUAL;
            r_fresh_ms   <= rdsps_pkg::RST_FRESH_MS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rdsps_pkg::CFG_COMMIT_THR: r_commit_thr <= i_cfg_data[rdsps_pkg::THR_W-1:0];
                rdsps_pkg::CFG_CHANGE_THR: r_change_thr <= i_cfg_data[rdsps_pkg::THR_W-1:0];
                rdsps_pkg::CFG_MIN_QUAL:   r_min_qual   <= i_cfg_data[rdsps_pkg::QUAL_W-1:0];
                rdsps_pkg::CFG_FRESH_MS:   r_fresh_ms   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Segment control state and committed values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_committed <= '0;
            for (int s = 0; s < SEGS; s++) begin
                r_fill[s]  <= '0;
                r_slot[s]  <= '0;
                r_value[s] <= '0;
                r_ctime[s] <= '0;
            end
        end else if (advance && use_group) begin
            r_fill[seg] <= n_fill;
            r_slot[seg] <= n_slot;
            if (do_commit) begin
                r_committed[seg] <= 1'b1;
                r_value[seg]     <= winner;
                r_ctime[seg]     <= r_in.time_ms;
            end
        end
    end

    // Vote window samples, written at the segment's ring slot.
    always_ff @(posedge i_clk) begin
        if (advance && use_group) begin
            r_win[seg][r_slot[seg]] <= sample;
        end
    end

endmodule
